/* design/trpd_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// trpd_pkg
// Shared types and constants for the Targa RLE pixel decoder.
// ============================================================================
package trpd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_RLE_ENABLED  = 2'd1;
  localparam logic [1:0] REG_PIXEL_COUNT  = 2'd2;

  // Pixel format codes; the unused code decodes as 32-bit.
  localparam logic [1:0] FMT_RGB555 = 2'd0;
  localparam logic [1:0] FMT_RGB24  = 2'd1;
  localparam logic [1:0] FMT_RGB32  = 2'd2;

  localparam int          COUNT_W    = 30;
  localparam logic [7:0]  RUN_FLAG   = 8'h80;
  localparam logic [7:0]  COUNT_MASK = 8'h7f;
  localparam logic [4:0]  FIELD_MASK = 5'h1f;

  // One finished pixel, handed from the front part to the back part.
  typedef struct packed {
    logic [23:0] pix;
    logic        fmt16;
    logic [7:0]  rep;
    logic        done;
  } trpd_item_t;

endpackage

/* design/trpd_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// trpd_front
// Accepts data bytes, parses packet headers, assembles pixels and tracks the
// image pixel budget. Emits one item per finished pixel.
// ============================================================================
module trpd_front
  import trpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               item_push,
  output trpd_item_t         item
);

  logic [1:0]         fmt_r;
  logic               rle_r;
  logic [COUNT_W-1:0] count_r;

  logic [COUNT_W-1:0] emitted_r, emitted_nxt, emitted_eff;
  logic [COUNT_W:0]   rem_r, rem_nxt, rem_eff;
  logic [1:0]         pos_r, pos_nxt, pos_eff;
  logic [23:0]        pix_r, pix_nxt, pix_eff;
  logic [7:0]         left_r, left_nxt, left_eff;
  logic               run_r, run_nxt, run_eff;
  logic               await_r, await_nxt, await_eff;

  logic       active;
  logic [1:0] last_pos;
  logic [7:0] rep;
  logic       emit;

  // Frame start clears decode state and reloads the remainder before the byte.
  always_comb begin
    if (frame_start) begin
      emitted_eff = '0;
      rem_eff     = {1'b0, count_r};
      pos_eff     = '0;
      pix_eff     = '0;
      left_eff    = '0;
      run_eff     = 1'b0;
      await_eff   = 1'b1;
    end else begin
      emitted_eff = emitted_r;
      rem_eff     = rem_r;
      pos_eff     = pos_r;
      pix_eff     = pix_r;
      left_eff    = left_r;
      run_eff     = run_r;
      await_eff   = await_r;
    end
  end

  // The image still has pixels to give while the remaining count is positive.
  assign active = !rem_eff[COUNT_W] && (|rem_eff);

  always_comb begin
    case (fmt_r)
      FMT_RGB555: last_pos = 2'd1;
      FMT_RGB24:  last_pos = 2'd2;
      default:    last_pos = 2'd3;
    endcase
  end

  // Per-byte decode step.
  always_comb begin
    emitted_nxt = emitted_eff;
    rem_nxt     = rem_eff;
    pos_nxt     = pos_eff;
    pix_nxt     = pix_eff;
    left_nxt    = left_eff;
    run_nxt     = run_eff;
    await_nxt   = await_eff;
    rep         = 8'd1;
    emit        = 1'b0;
    if (active) begin
      if (rle_r && await_eff) begin
        // Packet header byte.
        run_nxt   = |(data_byte & RUN_FLAG);
        left_nxt  = (data_byte & COUNT_MASK) + 8'd1;
        await_nxt = 1'b0;
        pos_nxt   = '0;
      end else begin
        case (pos_eff)
          2'd0:    pix_nxt[7:0]   = data_byte;
          2'd1:    pix_nxt[15:8]  = data_byte;
          2'd2:    pix_nxt[23:16] = data_byte;
          default: pix_nxt        = pix_eff;
        endcase
        if (pos_eff < last_pos) begin
          pos_nxt = pos_eff + 2'd1;
        end else begin
          pos_nxt = '0;
          emit    = 1'b1;
          if (rle_r) begin
            if (run_eff) begin
              rep      = (left_eff == 8'd0) ? 8'd1 : left_eff;
              left_nxt = '0;
            end else begin
              left_nxt = (left_eff != 8'd0) ? left_eff - 8'd1 : 8'd0;
            end
            if (left_nxt == 8'd0) begin
              await_nxt = 1'b1;
            end
          end
          // Clamp the repeat to the pixels still owed.
          if ((rem_eff[COUNT_W-1:8] == '0) && (rem_eff[7:0] < rep)) begin
            rep = rem_eff[7:0];
          end
          rem_nxt     = rem_eff - {{(COUNT_W-7){1'b0}}, rep};
          emitted_nxt = emitted_eff + {{(COUNT_W-8){1'b0}}, rep};
        end
      end
    end
  end

  assign item_push  = accept && emit;
  assign item.pix   = pix_nxt;
  assign item.fmt16 = (fmt_r == FMT_RGB555);
  assign item.rep   = rep;
  assign item.done  = (rem_nxt == '0);

  // Config and decode registers; a new pixel count also rebases the remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_RGB24;
      rle_r     <= 1'b1;
      count_r   <= '0;
      emitted_r <= '0;
      rem_r     <= '0;
      pos_r     <= '0;
      pix_r     <= '0;
      left_r    <= '0;
      run_r     <= 1'b0;
      await_r   <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PIXEL_FORMAT: fmt_r <= cfg_wdata[1:0];
          REG_RLE_ENABLED:  rle_r <= cfg_wdata[0];
          REG_PIXEL_COUNT: begin
            count_r <= cfg_wdata;
            rem_r   <= {1'b0, cfg_wdata} - {1'b0, emitted_r};
          end
          default: ;
        endcase
      end
      if (accept) begin
        emitted_r <= emitted_nxt;
        rem_r     <= rem_nxt;
        pos_r     <= pos_nxt;
        pix_r     <= pix_nxt;
        left_r    <= left_nxt;
        run_r     <= run_nxt;
        await_r   <= await_nxt;
      end
    end
  end

endmodule

/* design/trpd_fifo.sv */
`timescale 1ns / 1ps
// ============================================================================
// trpd_fifo
// Short item queue between the front and back parts.
// ============================================================================
module trpd_fifo
  import trpd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  trpd_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output trpd_item_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  trpd_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_MAX);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* design/trpd_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// trpd_back
// Converts queued pixels to 8-bit RGB and holds the result in the output
// register until it is popped.
// ============================================================================
module trpd_back
  import trpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  trpd_item_t q_head,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_repeat_res,
  output logic       out_image_done
);

  logic       valid_r;
  logic [7:0] red, green, blue;

  // Color conversion: 5:5:5 fields scaled by 8, otherwise B,G,R byte order.
  always_comb begin
    if (q_head.fmt16) begin
      red   = {q_head.pix[14:10] & FIELD_MASK, 3'b000};
      green = {q_head.pix[9:5] & FIELD_MASK, 3'b000};
      blue  = {q_head.pix[4:0] & FIELD_MASK, 3'b000};
    end else begin
      red   = q_head.pix[23:16];
      green = q_head.pix[15:8];
      blue  = q_head.pix[7:0];
    end
  end

  // Refill the output register whenever it is free or being taken.
  assign q_pop     = !q_empty && (!valid_r || out_pop);
  assign out_empty = !valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_red        <= red;
      out_green      <= green;
      out_blue       <= blue;
      out_repeat_res <= q_head.rep;
      out_image_done <= q_head.done;
    end
  end

endmodule

/* design/tga_rle_pixel_decoder_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// tga_rle_pixel_decoder_core
// Targa pixel-data decoder: raw or run-length packets, 16/24/32-bit pixels,
// one decoded RGB result with a repeat count per finished pixel.
// ============================================================================
//
//   Port group   Direction  Handshake            Carries
//   in_*         input      in_push / in_full    data_byte, frame_start
//   out_*        output     out_pop / out_empty  red, green, blue, repeat, done
//   cfg_*        input      cfg_wr_en            format, RLE enable, pixel count
//
// One byte is accepted per cycle while in_full is low; the front part updates
// all decode state in the cycle a byte is taken. A finished pixel passes
// through the item queue and then the output register before it reaches the
// out_ ports, and waits in the queue while the output register is held.
// Reset (synchronous, rst_n) clears control state, not queue or output data.
// in_full rises only when the item queue is full behind a stalled output;
// header bytes and skipped bytes are taken without producing a result.
// ============================================================================
module tga_rle_pixel_decoder_core
  import trpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_start,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_repeat_res,
  output logic               out_image_done
);

  logic       q_full, q_empty, q_pop, item_push;
  trpd_item_t item, q_head;

  assign in_full = q_full;

  // Front: byte parsing and pixel budget.
  trpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .accept      (in_push && !q_full),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .item_push   (item_push),
    .item        (item)
  );

  // Queue between the two parts.
  trpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_push),
    .push_item (item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: color conversion and output register.
  trpd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_repeat_res (out_repeat_res),
    .out_image_done (out_image_done)
  );

endmodule
